// File: rtl/core/jss_pkg.sv
// Package for the Jensen-Shannon similarity block.
// Holds fixed-point formats, derived widths, sequencer types and small helpers.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package jss_pkg;

    localparam int FRAC_BITS      = 20;
    localparam int LOG_TABLE_BITS = 20;
    localparam int ACC_WIDTH      = 48;
    localparam int LOG_FRAC       = 16;
    localparam int MANT_FRAC      = 30;

    localparam int IN_W   = 21;
    localparam int IDX_W  = LOG_TABLE_BITS + 1;
    localparam int MANT_W = MANT_FRAC + 1;
    localparam int K_W    = $clog2(LOG_TABLE_BITS + 1);
    localparam int ENT_W  = K_W + LOG_FRAC;
    localparam int TERM_W = IN_W + ENT_W - LOG_FRAC;
    localparam int ITER_W = $clog2(LOG_FRAC);
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int RAD_W  = 2 * FRAC_BITS;

    localparam int IDX_SHR = (FRAC_BITS >= LOG_TABLE_BITS) ? FRAC_BITS - LOG_TABLE_BITS : 0;
    localparam int IDX_SHL = (LOG_TABLE_BITS > FRAC_BITS) ? LOG_TABLE_BITS - FRAC_BITS : 0;

    localparam logic [IN_W-1:0] ONE_VAL = IN_W'(64'd1 << FRAC_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_NORM,
        S_SQ,
        S_SQ_UPD,
        S_W,
        S_ACC,
        S_FIN,
        S_JS,
        S_ROOT,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SRC_P,
        SRC_Q,
        SRC_M
    } t_src;

    typedef struct packed {
        logic                 done;
        logic [FRAC_BITS-1:0] root;
    } t_sqrt_res;

    function automatic logic [IDX_W-1:0] rom_index(input logic [IN_W-1:0] v);
        logic [IDX_W+IN_W-1:0] w;
        w = (IDX_W + IN_W)'(v);
        if (FRAC_BITS >= LOG_TABLE_BITS) begin
            w = w >> IDX_SHR;
        end else begin
            w = w << IDX_SHL;
        end
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [IN_W-1:0] sat_one(input logic [IN_W-1:0] v);
        return (v > ONE_VAL) ? ONE_VAL : v;
    endfunction

endpackage

// File: rtl/core/jensen_shannon_similarity.sv
// Jensen-Shannon similarity of two streamed probability vectors.
// Depends on jss_pkg, jss_mul and jss_sqrt.
//
// Input channel: i_valid / o_stall carry one element pair (p, q, last flag) per
// word, Q1.20 unsigned, values above 1.0 saturated. Output channel: o_valid /
// i_stall carry one similarity word per vector pair, after the last element.
// Each of p, q and m = (p+q)/2 runs through the shared multiplier: a
// normalizing shift by k bits (k = leading zeros below 1.0, up to 20), 16
// squarings, then one weighting product and accumulate; a zero value skips
// all of these. o_stall stays high while an item is in work, so a new pair
// is taken only after the last one has left the sequencer around the one
// multiplier. A last element then adds the divergence, a 20-step bit-serial
// square root (skipped when the divergence is below zero or at least 1.0),
// then the word moves to the output register.
// A result word held under i_stall keeps o_valid and o_similarity stable; the
// block accepts the next pair while it waits, and holds in its final state only
// if a second result is ready before the first is taken.
// Reset (synchronous, active low) clears both sums, the output valid and the
// sequencer; o_stall is high while reset is asserted.
module jensen_shannon_similarity (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [jss_pkg::IN_W-1:0] i_p_value,
    input  logic [jss_pkg::IN_W-1:0] i_q_value,
    input  logic                     i_last_element,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [jss_pkg::IN_W-1:0] o_similarity
);

    localparam int IW = jss_pkg::IN_W;
    localparam int AW = jss_pkg::ACC_WIDTH;
    localparam int MW = jss_pkg::MANT_W;
    localparam int FB = jss_pkg::FRAC_BITS;

    jss_pkg::t_state r_state, n_state;
    jss_pkg::t_src   r_sel, n_sel;

    logic                         r_ovalid, n_ovalid;
    logic [IW-1:0]                r_osim, n_osim;
    logic [AW-1:0]                r_ent, n_ent;
    logic [AW-1:0]                r_mix, n_mix;
    logic [IW-1:0]                r_p, n_p;
    logic [IW-1:0]                r_q, n_q;
    logic [IW-1:0]                r_m, n_m;
    logic                         r_last, n_last;
    logic [IW-1:0]                r_val, n_val;
    logic [MW-1:0]                r_x, n_x;
    logic [jss_pkg::K_W-1:0]      r_k, n_k;
    logic [jss_pkg::LOG_FRAC-1:0] r_frac, n_frac;
    logic [jss_pkg::ITER_W-1:0]   r_iter, n_iter;
    logic [AW:0]                  r_diff, n_diff;
    logic [IW-1:0]                r_sim, n_sim;

    logic [IW-1:0]                sat_p, sat_q, cur_val;
    logic [IW:0]                  pq_sum;
    logic [jss_pkg::IDX_W-1:0]    cur_idx;
    logic [jss_pkg::ENT_W-1:0]    entry;
    logic [MW:0]                  sq;
    logic [jss_pkg::TERM_W-1:0]   term;
    logic [AW:0]                  acc_sum, acc_in;
    logic [jss_pkg::MUL_W-1:0]    mul_a, mul_b;
    logic [jss_pkg::PROD_W-1:0]   prod;
    logic                         sqrt_start;
    logic [jss_pkg::RAD_W-1:0]    radicand;
    jss_pkg::t_sqrt_res           sqrt_res;

    jss_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    jss_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (radicand),
        .o_res      (sqrt_res)
    );

    assign sat_p    = jss_pkg::sat_one(i_p_value);
    assign sat_q    = jss_pkg::sat_one(i_q_value);
    assign pq_sum   = {1'b0, sat_p} + {1'b0, sat_q};
    assign cur_val  = (r_sel == jss_pkg::SRC_P) ? r_p :
                      (r_sel == jss_pkg::SRC_Q) ? r_q : r_m;
    assign cur_idx  = jss_pkg::rom_index(cur_val);
    assign entry    = (jss_pkg::ENT_W'(r_k) << jss_pkg::LOG_FRAC)
                      - jss_pkg::ENT_W'(r_frac);
    assign sq       = prod[jss_pkg::MANT_FRAC +: MW + 1];
    assign term     = prod[jss_pkg::LOG_FRAC +: jss_pkg::TERM_W];
    assign acc_in   = (r_sel == jss_pkg::SRC_M) ? {1'b0, r_mix} : {1'b0, r_ent};
    assign acc_sum  = acc_in + (AW + 1)'(term);
    assign radicand = {r_diff[FB-1:0], {FB{1'b0}}};

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        n_ovalid   = r_ovalid && i_stall;
        n_osim     = r_osim;
        n_ent      = r_ent;
        n_mix      = r_mix;
        n_p        = r_p;
        n_q        = r_q;
        n_m        = r_m;
        n_last     = r_last;
        n_val      = r_val;
        n_x        = r_x;
        n_k        = r_k;
        n_frac     = r_frac;
        n_iter     = r_iter;
        n_diff     = r_diff;
        n_sim      = r_sim;
        mul_a      = '0;
        mul_b      = '0;
        sqrt_start = 1'b0;

        case (r_state)
            jss_pkg::S_IDLE: begin
                if (i_valid && i_rst_n) begin
                    n_p     = sat_p;
                    n_q     = sat_q;
                    n_m     = pq_sum[IW:1];
                    n_last  = i_last_element;
                    n_sel   = jss_pkg::SRC_P;
                    n_state = jss_pkg::S_LOAD;
                end
            end
            jss_pkg::S_LOAD: begin
                n_val  = cur_val;
                n_x    = MW'(cur_idx) << (jss_pkg::MANT_FRAC - jss_pkg::LOG_TABLE_BITS);
                n_k    = '0;
                n_frac = '0;
                n_iter = '0;
                if (cur_idx != '0) begin
                    n_state = jss_pkg::S_NORM;
                end else if (r_sel == jss_pkg::SRC_M) begin
                    n_state = r_last ? jss_pkg::S_FIN : jss_pkg::S_IDLE;
                end else begin
                    n_sel   = (r_sel == jss_pkg::SRC_P) ? jss_pkg::SRC_Q : jss_pkg::SRC_M;
                    n_state = jss_pkg::S_LOAD;
                end
            end
            jss_pkg::S_NORM: begin
                if (r_x[jss_pkg::MANT_FRAC]) begin
                    n_state = jss_pkg::S_SQ;
                end else begin
                    n_x = r_x << 1;
                    n_k = r_k + 1'b1;
                end
            end
            jss_pkg::S_SQ: begin
                mul_a   = jss_pkg::MUL_W'(r_x);
                mul_b   = jss_pkg::MUL_W'(r_x);
                n_state = jss_pkg::S_SQ_UPD;
            end
            jss_pkg::S_SQ_UPD: begin
                if (sq[MW]) begin
                    n_x    = sq[MW:1];
                    n_frac = {r_frac[jss_pkg::LOG_FRAC-2:0], 1'b1};
                end else begin
                    n_x    = sq[MW-1:0];
                    n_frac = {r_frac[jss_pkg::LOG_FRAC-2:0], 1'b0};
                end
                n_iter = r_iter + 1'b1;
                if (r_iter == jss_pkg::ITER_W'(jss_pkg::LOG_FRAC - 1)) begin
                    n_state = jss_pkg::S_W;
                end else begin
                    n_state = jss_pkg::S_SQ;
                end
            end
            jss_pkg::S_W: begin
                mul_a   = jss_pkg::MUL_W'(r_val);
                mul_b   = jss_pkg::MUL_W'(entry);
                n_state = jss_pkg::S_ACC;
            end
            jss_pkg::S_ACC: begin
                if (r_sel == jss_pkg::SRC_M) begin
                    n_mix   = acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0];
                    n_state = r_last ? jss_pkg::S_FIN : jss_pkg::S_IDLE;
                end else begin
                    n_ent   = acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0];
                    n_sel   = (r_sel == jss_pkg::SRC_P) ? jss_pkg::SRC_Q : jss_pkg::SRC_M;
                    n_state = jss_pkg::S_LOAD;
                end
            end
            jss_pkg::S_FIN: begin
                n_diff  = {1'b0, r_mix} - {2'b00, r_ent[AW-1:1]};
                n_ent   = '0;
                n_mix   = '0;
                n_state = jss_pkg::S_JS;
            end
            jss_pkg::S_JS: begin
                if (r_diff[AW]) begin
                    n_sim   = jss_pkg::ONE_VAL;
                    n_state = jss_pkg::S_EMIT;
                end else if (r_diff[AW-1:0] >= AW'(jss_pkg::ONE_VAL)) begin
                    n_sim   = '0;
                    n_state = jss_pkg::S_EMIT;
                end else begin
                    sqrt_start = 1'b1;
                    n_state    = jss_pkg::S_ROOT;
                end
            end
            jss_pkg::S_ROOT: begin
                if (sqrt_res.done) begin
                    n_sim   = (IW'(sqrt_res.root) >= jss_pkg::ONE_VAL) ? '0 :
                              jss_pkg::ONE_VAL - IW'(sqrt_res.root);
                    n_state = jss_pkg::S_EMIT;
                end
            end
            jss_pkg::S_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_osim   = r_sim;
                    n_state  = jss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = jss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= jss_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_ent    <= '0;
            r_mix    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_ent    <= n_ent;
            r_mix    <= n_mix;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel  <= n_sel;
        r_osim <= n_osim;
        r_p    <= n_p;
        r_q    <= n_q;
        r_m    <= n_m;
        r_last <= n_last;
        r_val  <= n_val;
        r_x    <= n_x;
        r_k    <= n_k;
        r_frac <= n_frac;
        r_iter <= n_iter;
        r_diff <= n_diff;
        r_sim  <= n_sim;
    end

    assign o_stall      = (r_state != jss_pkg::S_IDLE) || !i_rst_n;
    assign o_valid      = r_ovalid;
    assign o_similarity = r_osim;

endmodule

// File: rtl/core/jss_mul.sv
// Shared multiplier: one unsigned product per cycle, result registered.
// Used for the log mantissa squarings and the value-times-log weighting.
// Depends on jss_pkg.
module jss_mul (
    input  logic                       i_clk,
    input  logic [jss_pkg::MUL_W-1:0]  i_a,
    input  logic [jss_pkg::MUL_W-1:0]  i_b,
    output logic [jss_pkg::PROD_W-1:0] o_prod
);

    logic [jss_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= jss_pkg::PROD_W'(i_a) * jss_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/jss_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Takes a RAD_W-bit radicand on a start pulse and returns the floor root.
// Depends on jss_pkg.
module jss_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [jss_pkg::RAD_W-1:0] i_radicand,
    output jss_pkg::t_sqrt_res        o_res
);

    localparam int RW = jss_pkg::RAD_W;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [RW-1:0] r_n, n_n;
    logic [RW-1:0] r_res, n_res;
    logic [RW-1:0] r_bit, n_bit;
    logic [RW-1:0] trial;

    always_comb begin
        trial  = r_res + r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        n_n    = r_n;
        n_res  = r_res;
        n_bit  = r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_n    = i_radicand;
            n_res  = '0;
            n_bit  = RW'(1) << (RW - 2);
        end else if (r_busy) begin
            if (r_n >= trial) begin
                n_n   = r_n - trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit[0]) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_res.done = r_done;
    assign o_res.root = r_res[jss_pkg::FRAC_BITS-1:0];

endmodule

// File: rtl/core/jss_checker.sv
// Port-level checks for jensen_shannon_similarity, bound to the top level.
// Depends on jss_pkg; watches the top-level ports only.
module jss_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input logic [jss_pkg::IN_W-1:0] i_p_value,
    input logic [jss_pkg::IN_W-1:0] i_q_value,
    input logic                     i_last_element,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic [jss_pkg::IN_W-1:0] o_similarity
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted back to back");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=>
        (i_valid && $stable({i_p_value, i_q_value, i_last_element})))
        else $error("stalled input word changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_similarity)))
        else $error("stalled output word changed");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_similarity <= jss_pkg::ONE_VAL))
        else $error("similarity above one");

    a_ready_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_stall)
        else $error("result loaded while input side still busy");

endmodule

bind jensen_shannon_similarity jss_checker u_jss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_p_value      (i_p_value),
    .i_q_value      (i_q_value),
    .i_last_element (i_last_element),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_similarity   (o_similarity)
);
